FILE: sv/sem_pkg.sv
package sem_pkg;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int DIFF_W   = 9;
    localparam int SOB_W    = 11;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int LIM_W    = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam int MIN_DIM = 3;

    // Square root unit: one result bit per step
    localparam int RAD_W       = 22;
    localparam int ROOT_W      = 11;
    localparam int SQRT_STEPS  = 11;
    localparam int STEP_CNT_W  = 4;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // latch pixel, counters and issue line store read
        logic shift;     // shift window, write line stores
        logic square;    // register gradient squares
        logic start;     // load square root units
        logic step;      // one square root iteration
        logic load_out;  // load output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/sem_pix_if.sv
interface sem_pix_if;
    logic                     valid;
    logic                     ready;
    logic [sem_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

FILE: sv/sem_res_if.sv
interface sem_res_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::DIFF_W-1:0] diff_magnitude;
    logic [sem_pkg::SOB_W-1:0]  sobel_magnitude;
    logic                      sobel_valid;
    logic                      frame_last;

    modport source (
        output valid, output diff_magnitude, output sobel_magnitude,
        output sobel_valid, output frame_last, input ready
    );
    modport sink (
        input valid, input diff_magnitude, input sobel_magnitude,
        input sobel_valid, input frame_last, output ready
    );
endinterface

FILE: sv/sem_isqrt.sv
module sem_isqrt (
    input  logic                         i_clk,
    input  logic                         i_start,
    input  logic                         i_step,
    input  logic [sem_pkg::RAD_W-1:0]    i_radicand,
    output logic [sem_pkg::ROOT_W-1:0]   o_root
);

    localparam int REM_W = sem_pkg::ROOT_W + 2;

    logic [sem_pkg::RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [sem_pkg::ROOT_W-1:0] r_root;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    // Bring down the next two radicand bits and try the next root bit
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[sem_pkg::RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_step) begin
            r_rad <= {r_rad[sem_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[sem_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[sem_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;

endmodule

FILE: sv/sem_ctrl.sv
module sem_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sem_pkg::t_dp_status i_status,
    output sem_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_ROOT   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [sem_pkg::STEP_CNT_W-1:0] LAST_STEP =
        sem_pkg::STEP_CNT_W'(sem_pkg::SQRT_STEPS - 1);

    logic [2:0]                       r_state, n_state;
    logic [sem_pkg::STEP_CNT_W-1:0]   r_count, n_count;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.shift = 1'b1;
                n_state     = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.start = 1'b1;
                n_count     = '0;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.step = 1'b1;
                n_count    = r_count + 1'b1;
                if (r_count == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

FILE: sv/sem_datapath.sv
module sem_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [sem_pkg::PIX_W-1:0]         i_pixel,
    input  logic                              i_out_ready,
    input  sem_pkg::t_dp_cmd                  i_cmd,
    output sem_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    output logic [sem_pkg::DIFF_W-1:0]        o_diff_magnitude,
    output logic [sem_pkg::SOB_W-1:0]         o_sobel_magnitude,
    output logic                              o_sobel_valid,
    output logic                              o_frame_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [sem_pkg::LIM_W-1:0] MAXW = sem_pkg::LIM_W'(MAX_WIDTH);
    localparam logic [sem_pkg::LIM_W-1:0] MINW = sem_pkg::LIM_W'(sem_pkg::MIN_DIM);
    localparam logic [sem_pkg::HEIGHT_W-1:0] MINH =
        sem_pkg::HEIGHT_W'(sem_pkg::MIN_DIM);

    // Configuration
    logic [sem_pkg::WIDTH_W-1:0]  r_width;
    logic [sem_pkg::HEIGHT_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::WIDTH_RESET;
            r_height <= sem_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sem_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[sem_pkg::WIDTH_W-1:0];
                sem_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the frame size and the column in use
    logic [sem_pkg::LIM_W-1:0]    w_ext;
    logic [sem_pkg::LIM_W-1:0]    w_lim_full;
    logic [AW-1:0]                col_lim;
    logic [sem_pkg::HEIGHT_W-1:0] row_lim;
    logic [AW-1:0]                r_col, n_col;
    logic [sem_pkg::HEIGHT_W-1:0] r_row, n_row;
    logic [AW-1:0]                col;
    logic                         end_col;
    logic                         end_frame;

    assign w_ext = sem_pkg::LIM_W'(r_width);

    always_comb begin
        if (w_ext < MINW) begin
            w_lim_full = MINW - 1'b1;
        end else if (w_ext > MAXW) begin
            w_lim_full = MAXW - 1'b1;
        end else begin
            w_lim_full = w_ext - 1'b1;
        end
    end

    assign col_lim   = w_lim_full[AW-1:0];
    assign row_lim   = (r_height < MINH) ? (MINH - 1'b1) : (r_height - 1'b1);
    assign col       = (r_col > col_lim) ? col_lim : r_col;
    assign end_col   = (col == col_lim);
    assign end_frame = end_col && (r_row >= row_lim);

    // Advance the raster position
    always_comb begin
        n_col = col + 1'b1;
        n_row = r_row;
        if (end_col) begin
            n_col = '0;
            n_row = end_frame ? '0 : (r_row + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Latch the pixel, its column and its position flags
    logic [sem_pkg::PIX_W-1:0] r_p;
    logic [AW-1:0]             r_c;
    logic                      r_diff_border;
    logic                      r_sob_valid;
    logic                      r_sob_border;
    logic                      r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p           <= i_pixel;
            r_c           <= col;
            r_diff_border <= (r_row == '0) || (col == '0);
            r_sob_valid   <= (r_row != '0) && (col != '0);
            r_sob_border  <= (r_row == 12'd1) || (col == AW'(1));
            r_last        <= end_frame;
        end
    end

    // Line stores: row above and row two above
    logic [sem_pkg::PIX_W-1:0] r_mem_a [MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] r_mem_b [MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] r_rd_a;
    logic [sem_pkg::PIX_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_a <= r_mem_a[col];
        end
        if (i_cmd.shift) begin
            r_mem_a[r_c] <= r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_b <= r_mem_b[col];
        end
        if (i_cmd.shift) begin
            r_mem_b[r_c] <= r_rd_a;
        end
    end

    // 3x3 window, shift left and load the new column
    logic [sem_pkg::PIX_W-1:0] r_win [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_rd_b;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= r_rd_a;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_p;
        end
    end

    // Gradients and their squares
    logic signed [9:0]  fx, fy;
    logic signed [11:0] w0, w1, w2, w3, w5, w6, w7, w8;
    logic signed [11:0] gx, gy;
    logic [16:0]        r_fx_sq, r_fy_sq;
    logic [19:0]        r_gx_sq, r_gy_sq;

    assign fx = $signed({2'b00, r_win[8]}) - $signed({2'b00, r_win[5]});
    assign fy = $signed({2'b00, r_win[8]}) - $signed({2'b00, r_win[7]});
    assign w0 = $signed({4'b0000, r_win[0]});
    assign w1 = $signed({4'b0000, r_win[1]});
    assign w2 = $signed({4'b0000, r_win[2]});
    assign w3 = $signed({4'b0000, r_win[3]});
    assign w5 = $signed({4'b0000, r_win[5]});
    assign w6 = $signed({4'b0000, r_win[6]});
    assign w7 = $signed({4'b0000, r_win[7]});
    assign w8 = $signed({4'b0000, r_win[8]});
    assign gx = (w2 - w0) + ((w5 - w3) <<< 1) + (w8 - w6);
    assign gy = (w6 + (w7 <<< 1) + w8) - (w0 + (w1 <<< 1) + w2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_fx_sq <= 17'(fx * fx);
            r_fy_sq <= 17'(fy * fy);
            r_gx_sq <= 20'(gx * gx);
            r_gy_sq <= 20'(gy * gy);
        end
    end

    // Square root units
    logic [sem_pkg::RAD_W-1:0]  rad_diff, rad_sob;
    logic [sem_pkg::ROOT_W-1:0] root_diff, root_sob;

    assign rad_diff = sem_pkg::RAD_W'(r_fx_sq) + sem_pkg::RAD_W'(r_fy_sq);
    assign rad_sob  = sem_pkg::RAD_W'(r_gx_sq) + sem_pkg::RAD_W'(r_gy_sq);

    sem_isqrt u_isqrt_diff (
        .i_clk      (i_clk),
        .i_start    (i_cmd.start),
        .i_step     (i_cmd.step),
        .i_radicand (rad_diff),
        .o_root     (root_diff)
    );

    sem_isqrt u_isqrt_sob (
        .i_clk      (i_clk),
        .i_start    (i_cmd.start),
        .i_step     (i_cmd.step),
        .i_radicand (rad_sob),
        .o_root     (root_sob)
    );

    // Output register
    logic                      r_out_valid;
    logic [sem_pkg::DIFF_W-1:0] r_diff;
    logic [sem_pkg::SOB_W-1:0]  r_sob;
    logic                      r_out_sob_valid;
    logic                      r_out_last;

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_diff <= r_diff_border ? sem_pkg::DIFF_W'(r_p)
                                    : root_diff[sem_pkg::DIFF_W-1:0];
            if (!r_sob_valid) begin
                r_sob <= '0;
            end else if (r_sob_border) begin
                r_sob <= sem_pkg::SOB_W'(r_win[4]);
            end else begin
                r_sob <= root_sob;
            end
            r_out_sob_valid <= r_sob_valid;
            r_out_last      <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_diff_magnitude  = r_diff;
    assign o_sobel_magnitude = r_sob;
    assign o_sobel_valid     = r_out_sob_valid;
    assign o_frame_last      = r_out_last;

endmodule

FILE: sv/sobel_edge_magnitude_core.sv
// Each pixel passes in turn through line store read, window shift, squaring and
// the 11 iterations of the bit-serial square root units; its result then waits
// for the output register to be free, and only then is the next pixel taken.
// A pending result may wait in the output register while the next pixel is taken.
// Reset (synchronous, active low) clears the raster counters, window, state
// machine and output valid; configuration returns to 640 x 480.
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sem_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sem_pix_if.sink                        i_pix,
    sem_res_if.source                      o_res
);

    sem_pkg::t_dp_cmd    w_cmd;
    sem_pkg::t_dp_status w_status;
    logic                w_in_ready;

    sem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_pix.ready = w_in_ready;

    sem_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_pixel           (i_pix.pixel),
        .i_out_ready       (o_res.ready),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_out_valid       (o_res.valid),
        .o_diff_magnitude  (o_res.diff_magnitude),
        .o_sobel_magnitude (o_res.sobel_magnitude),
        .o_sobel_valid     (o_res.sobel_valid),
        .o_frame_last      (o_res.frame_last)
    );

    // Never overwrite a result that has not been taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_res.valid || o_res.ready))
        else $error("output register overwritten");

    // One pixel in flight: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("pixel taken while busy");

    // Datapath commands never overlap
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.shift, w_cmd.square, w_cmd.start,
                  w_cmd.step, w_cmd.load_out}))
        else $error("overlapping datapath commands");

    // No Sobel centre means a zero Sobel magnitude
    a_sob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.sobel_valid) |-> (o_res.sobel_magnitude == '0))
        else $error("Sobel magnitude without a centre");

endmodule

FILE: test/sobel_edge_magnitude_core_test.sv
`timescale 1ns / 100ps

module sobel_edge_magnitude_core_test;

    localparam int          LINE_LEN         = 1024;
    localparam int unsigned TOTAL_PIXELS     = 1150;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES      = 40;
    localparam int unsigned CYCLE_LIMIT      = 600000;

    typedef struct packed {
        logic [sem_pkg::DIFF_W-1:0] diff_magnitude;
        logic [sem_pkg::SOB_W-1:0]  sobel_magnitude;
        logic                       sobel_valid;
        logic                       frame_last;
    } t_edge_result;

    typedef enum int {
        STYLE_NOISE,
        STYLE_BINARY,
        STYLE_RAMP,
        STYLE_STEP
    } t_pattern;

    // Raster position, line stores and window of the edge filter, plus the
    // queue of magnitudes still owed by the block
    class t_edge_scoreboard;
        logic [sem_pkg::WIDTH_W-1:0]  width_reg;
        logic [sem_pkg::HEIGHT_W-1:0] height_reg;
        logic [sem_pkg::PIX_W-1:0]    row_above [LINE_LEN];
        logic [sem_pkg::PIX_W-1:0]    row_two_above [LINE_LEN];
        logic [sem_pkg::PIX_W-1:0]    win [9];
        bit                           touched_once [LINE_LEN];
        bit                           touched_twice [LINE_LEN];
        int unsigned                  col;
        int unsigned                  row;
        int unsigned                  error_count;
        t_edge_result                 pending [$];

        function new();
            width_reg  = sem_pkg::WIDTH_RESET;
            height_reg = sem_pkg::HEIGHT_RESET;
            foreach (row_above[i]) begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
                touched_once[i]  = 1'b0;
                touched_twice[i] = 1'b0;
            end
            foreach (win[i]) win[i] = '0;
            col         = 0;
            row         = 0;
            error_count = 0;
        endfunction

        function void set_register(logic [sem_pkg::CFG_IDX_W-1:0] idx,
                                   logic [sem_pkg::CFG_DATA_W-1:0] data);
            if (idx == sem_pkg::CFG_WIDTH)
                width_reg = data[sem_pkg::WIDTH_W-1:0];
            else if (idx == sem_pkg::CFG_HEIGHT)
                height_reg = data[sem_pkg::HEIGHT_W-1:0];
        endfunction

        function int unsigned active_width();
            int unsigned w;
            w = 32'(width_reg);
            if (w < sem_pkg::MIN_DIM) w = sem_pkg::MIN_DIM;
            if (w > LINE_LEN) w = LINE_LEN;
            return w;
        endfunction

        // Leading columns whose both line store entries hold defined data
        function int unsigned settled_columns();
            int unsigned n;
            n = 0;
            while (n < LINE_LEN && touched_twice[n]) n++;
            return n;
        endfunction

        function int unsigned floor_root(int unsigned v);
            int unsigned root;
            int unsigned trial;
            root = 0;
            for (int b = 11; b >= 0; b--) begin
                trial = root | (1 << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        // Advance the filter by one pixel; returns 1 on the last pixel of a frame
        function bit note_pixel(logic [sem_pkg::PIX_W-1:0] p);
            int unsigned  w, h, c, r;
            int           up_px, left_px, fx, fy, gx, gy;
            t_edge_result want;
            w = active_width();
            h = 32'(height_reg);
            if (h < sem_pkg::MIN_DIM) h = sem_pkg::MIN_DIM;
            if (col >= w) col = w - 1;
            c = col;
            r = row;
            up_px = int'(row_above[c]);

            // shift the window left and load the new column
            win[0] = win[1]; win[1] = win[2];
            win[3] = win[4]; win[4] = win[5];
            win[6] = win[7]; win[7] = win[8];
            win[2] = row_two_above[c];
            win[5] = row_above[c];
            win[8] = p;
            row_two_above[c] = row_above[c];
            row_above[c]     = p;
            if (touched_once[c]) touched_twice[c] = 1'b1;
            touched_once[c] = 1'b1;

            // backward difference at the current position
            left_px = int'(win[7]);
            if (r == 0 || c == 0) begin
                want.diff_magnitude = sem_pkg::DIFF_W'(p);
            end else begin
                fx = int'(p) - up_px;
                fy = int'(p) - left_px;
                want.diff_magnitude = sem_pkg::DIFF_W'(floor_root(fx * fx + fy * fy));
            end

            // Sobel for the centre one row and one column behind
            want.sobel_valid     = (r >= 1 && c >= 1);
            want.sobel_magnitude = '0;
            if (want.sobel_valid) begin
                if (r == 1 || c == 1) begin
                    want.sobel_magnitude = sem_pkg::SOB_W'(win[4]);
                end else begin
                    gx = (int'(win[2]) - int'(win[0])) + 2 * (int'(win[5]) - int'(win[3]))
                       + (int'(win[8]) - int'(win[6]));
                    gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
                       - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
                    want.sobel_magnitude = sem_pkg::SOB_W'(floor_root(gx * gx + gy * gy));
                end
            end

            // advance the raster position
            want.frame_last = 1'b0;
            if (c + 1 >= w) begin
                col = 0;
                if (r + 1 >= h) begin
                    row             = 0;
                    want.frame_last = 1'b1;
                end else begin
                    row = r + 1;
                end
            end else begin
                col = c + 1;
            end
            pending.push_back(want);
            return want.frame_last;
        endfunction

        function void check_result(t_edge_result got);
            t_edge_result want;
            if (pending.size() == 0) begin
                $error("result transaction with no pixel pending: diff_magnitude %0d",
                       got.diff_magnitude);
                error_count++;
                return;
            end
            want = pending.pop_front();
            if (got.diff_magnitude !== want.diff_magnitude) begin
                $error("diff_magnitude: expected %0d, actual %0d",
                       want.diff_magnitude, got.diff_magnitude);
                error_count++;
            end
            if (got.sobel_magnitude !== want.sobel_magnitude) begin
                $error("sobel_magnitude: expected %0d, actual %0d",
                       want.sobel_magnitude, got.sobel_magnitude);
                error_count++;
            end
            if (got.sobel_valid !== want.sobel_valid) begin
                $error("sobel_valid: expected %0d, actual %0d",
                       want.sobel_valid, got.sobel_valid);
                error_count++;
            end
            if (got.frame_last !== want.frame_last) begin
                $error("frame_last: expected %0d, actual %0d",
                       want.frame_last, got.frame_last);
                error_count++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [sem_pkg::CFG_DATA_W-1:0] cfg_data;

    sem_pix_if pix_if ();
    sem_res_if res_if ();

    t_edge_scoreboard sb = new();

    int unsigned pixels_sent     = 0;
    int unsigned cycle_count     = 0;
    bit          source_idle_en  = 1'b1;
    bit          sink_idle_en    = 1'b1;
    bit          long_hold_armed = 1'b0;

    sobel_edge_magnitude_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sobel_edge_magnitude_core test failed");
        $finish;
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_monitor
        t_edge_result got;
        if (res_if.valid && res_if.ready) begin
            got.diff_magnitude  = res_if.diff_magnitude;
            got.sobel_magnitude = res_if.sobel_magnitude;
            got.sobel_valid     = res_if.sobel_valid;
            got.frame_last      = res_if.frame_last;
            sb.check_result(got);
        end
    end

    // Result sink: drop ready for a random stretch after each transaction,
    // and once for a long hold-off so the block backs up into its input
    initial begin : result_sink
        int unsigned stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                if (long_hold_armed) begin
                    long_hold_armed = 1'b0;
                    stall = LONG_HOLD_CYCLES;
                end else begin
                    stall = sink_idle_en ? $urandom_range(0, 16) : 0;
                end
                if (stall != 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    res_if.ready <= 1'b1;
                end
            end
        end
    end

    // Offer one pixel and hold it until the block takes it
    task automatic send_pixel(input logic [sem_pkg::PIX_W-1:0] p, output bit frame_end);
        int unsigned gap;
        gap = source_idle_en ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        frame_end = sb.note_pixel(p);
        pixels_sent++;
    endtask

    // Let the block drain, then write both size registers
    task automatic reconfigure(input logic [sem_pkg::CFG_DATA_W-1:0] wdata,
                               input logic [sem_pkg::CFG_DATA_W-1:0] hdata);
        pix_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= sem_pkg::CFG_WIDTH;
        cfg_data <= wdata;
        @(posedge i_clk);
        sb.set_register(sem_pkg::CFG_WIDTH, wdata);
        cfg_idx  <= sem_pkg::CFG_HEIGHT;
        cfg_data <= hdata;
        @(posedge i_clk);
        sb.set_register(sem_pkg::CFG_HEIGHT, hdata);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [sem_pkg::PIX_W-1:0] make_pixel(t_pattern style);
        case (style)
            STYLE_NOISE:  return sem_pkg::PIX_W'($urandom_range(0, 255));
            STYLE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            STYLE_RAMP:   return 8'(sb.col * 23 + sb.row * 11 + $urandom_range(0, 3));
            default: begin
                if ((sb.col + 2 * sb.row) % 5 < 2)
                    return 8'(240 + $urandom_range(0, 15));
                return 8'($urandom_range(0, 15));
            end
        endcase
    endfunction

    // Resize in the middle of a frame: a height up to the current row plus five,
    // a narrower width, or a wider one only over defined line store entries
    task automatic resize_midframe();
        logic [sem_pkg::CFG_DATA_W-1:0] wdata;
        logic [sem_pkg::CFG_DATA_W-1:0] hdata;
        int unsigned                    cur_w;
        int unsigned                    top_w;
        cur_w = sb.active_width();
        wdata = {1'b0, sb.width_reg};
        hdata = sb.height_reg;
        case ($urandom_range(0, 2))
            0: hdata = sem_pkg::CFG_DATA_W'($urandom_range(0, sb.row + 5));
            1: wdata[sem_pkg::WIDTH_W-1:0] = sem_pkg::WIDTH_W'($urandom_range(0, cur_w));
            default: begin
                top_w = sb.settled_columns();
                if (top_w < cur_w) top_w = cur_w;
                wdata[sem_pkg::WIDTH_W-1:0] =
                    sem_pkg::WIDTH_W'($urandom_range(cur_w, top_w));
            end
        endcase
        wdata[sem_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
        reconfigure(wdata, hdata);
    endtask

    task automatic run_frame(input logic [sem_pkg::CFG_DATA_W-1:0] wdata,
                             input logic [sem_pkg::CFG_DATA_W-1:0] hdata,
                             input t_pattern style, input bit midframe);
        bit          done;
        int unsigned split_at;
        int unsigned k;
        reconfigure(wdata, hdata);
        split_at = midframe ? $urandom_range(1, 40) : 0;
        done = 1'b0;
        k = 0;
        while (!done) begin
            if (split_at != 0 && k == split_at) resize_midframe();
            send_pixel(make_pixel(style), done);
            k++;
        end
    endtask

    initial begin : stimulus
        logic [sem_pkg::PIX_W-1:0] probe [25] = '{
            8'd0,   8'd255, 8'd0,   8'd255, 8'd0,
            8'd255, 8'd0,   8'd255, 8'd0,   8'd255,
            8'd0,   8'd0,   8'd0,   8'd255, 8'd255,
            8'd0,   8'd1,   8'd255, 8'd255, 8'd254,
            8'd0,   8'd255, 8'd255, 8'd255, 8'd128
        };
        logic [sem_pkg::CFG_DATA_W-1:0] wdata;
        logic [sem_pkg::CFG_DATA_W-1:0] hdata;
        int unsigned                    frame_no;
        int unsigned                    sel;
        bit                             done;

        // Hold reset with every input at rest
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= sem_pkg::CFG_WIDTH;
        cfg_data     <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small frame: checkerboard for the largest differences, then edges
        reconfigure(12'd5, 12'd5);
        foreach (probe[i]) send_pixel(probe[i], done);

        // Widest frame and tallest height, cut short by resizing mid-frame
        reconfigure(12'd1024, 12'd4095);
        repeat (30) send_pixel(make_pixel(STYLE_NOISE), done);
        reconfigure(12'hFFF, 12'd4095);
        repeat (10) send_pixel(make_pixel(STYLE_STEP), done);
        reconfigure(12'h805, 12'd0);
        done = 1'b0;
        while (!done) send_pixel(make_pixel(STYLE_BINARY), done);

        // Random frames
        frame_no = 0;
        while (pixels_sent < TOTAL_PIXELS) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                wdata = sem_pkg::CFG_DATA_W'($urandom_range(3, 12));
            else if (sel < 9)
                wdata = sem_pkg::CFG_DATA_W'($urandom_range(13, 40));
            else
                wdata = sem_pkg::CFG_DATA_W'($urandom_range(0, 2));
            wdata[sem_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 9);
            if (sel < 8)
                hdata = sem_pkg::CFG_DATA_W'($urandom_range(3, 6));
            else if (sel < 9)
                hdata = sem_pkg::CFG_DATA_W'($urandom_range(7, 10));
            else
                hdata = sem_pkg::CFG_DATA_W'($urandom_range(0, 2));
            source_idle_en = ($urandom_range(0, 3) != 0);
            sink_idle_en   = ($urandom_range(0, 3) != 0);

            // one frame keeps offering pixels while the sink holds off
            if (frame_no == 2) begin
                wdata           = 12'd12;
                hdata           = 12'd5;
                source_idle_en  = 1'b0;
                long_hold_armed = 1'b1;
            end
            run_frame(wdata, hdata, t_pattern'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0));
            frame_no++;
        end

        // Wait for the last results, then a short tail for strays
        pix_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending.size() == 0) begin
            $display("sobel_edge_magnitude_core test passed");
        end else begin
            $display("sobel_edge_magnitude_core test failed");
        end
        $finish;
    end

endmodule
